// ===== hdl/gbl_pkg.sv =====
// Shared types and key codes for the gap buffer line editor.
`timescale 1ns / 1ps
package gbl_pkg;

    localparam logic [7:0] KEY_DEL     = 8'd127;
    localparam logic [7:0] KEY_CR      = 8'd13;
    localparam logic [7:0] KEY_ESC     = 8'h1B;
    localparam logic [7:0] KEY_QUIT    = 8'h71;
    localparam logic [7:0] KEY_LEFT    = 8'h44;
    localparam logic [7:0] KEY_RIGHT   = 8'h43;
    localparam logic [7:0] KEY_BRACKET = 8'h5B;

    localparam logic OPC_KEY  = 1'b0;
    localparam logic OPC_READ = 1'b1;

    typedef enum logic [2:0] {
        OP_READ,
        OP_LEFT,
        OP_RIGHT,
        OP_DEL,
        OP_INS,
        OP_NOP
    } op_kind_t;

    typedef struct packed {
        op_kind_t   kind;
        logic [7:0] key;
        logic [7:0] position;
        logic       esc;
    } cmd_t;

endpackage

// ===== hdl/gap_buffer_line_editor_top.sv =====
// Top level of the gap buffer line editor.
//
//  channel | handshake            | words
//  --------+----------------------+---------------------------------------------
//  in      | in_valid / in_stall  | opcode, key, position
//  out     | out_valid / out_stall| cursor, text_length, read_char, refused,
//          |                      | escape_active
//
// A cursor key, a refused insert or a key that does nothing passes through the
// execute and post states of the edit engine, and a read also waits on the memory
// read; a delete or an insert first moves the gap to the cursor, the text memory
// copying one byte a cycle, then writes or drops the character.
// The front end keeps accepting words into a two-entry queue while the engine
// works or its result waits behind out_stall. Reset empties the text; the memory
// itself is not cleared.
`timescale 1ns / 1ps
module gap_buffer_line_editor_top #(
    parameter int CAPACITY = 256
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       opcode,
    input  logic [7:0] key,
    input  logic [7:0] position,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [8:0] cursor,
    output logic [8:0] text_length,
    output logic [7:0] read_char,
    output logic       refused,
    output logic       escape_active
);

    gbl_pkg::cmd_t push_data;
    gbl_pkg::cmd_t head_data;
    logic          q_push;
    logic          q_full;
    logic          q_pop;
    logic          q_empty;

    gbl_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .opcode   (opcode),
        .key      (key),
        .position (position),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (push_data)
    );

    gbl_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (push_data),
        .full  (q_full),
        .pop   (q_pop),
        .dout  (head_data),
        .empty (q_empty)
    );

    gbl_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_dout        (head_data),
        .q_empty       (q_empty),
        .q_pop         (q_pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .cursor        (cursor),
        .text_length   (text_length),
        .read_char     (read_char),
        .refused       (refused),
        .escape_active (escape_active)
    );

endmodule

// ===== hdl/gbl_front.sv =====
// Front end: accepts input words, tracks escape mode and classifies each word.
`timescale 1ns / 1ps
module gbl_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  logic          opcode,
    input  logic [7:0]    key,
    input  logic [7:0]    position,
    input  logic          q_full,
    output logic          q_push,
    output gbl_pkg::cmd_t q_data
);

    logic esc_reg;
    logic esc_next;
    gbl_pkg::op_kind_t kind;

    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;

    always_comb
    begin
        kind     = gbl_pkg::OP_NOP;
        esc_next = esc_reg;
        if (opcode == gbl_pkg::OPC_READ)
        begin
            kind = gbl_pkg::OP_READ;
        end
        else if (esc_reg)
        begin
            // any byte but the bracket ends the sequence
            if (key == gbl_pkg::KEY_LEFT)
            begin
                kind     = gbl_pkg::OP_LEFT;
                esc_next = 1'b0;
            end
            else if (key == gbl_pkg::KEY_RIGHT)
            begin
                kind     = gbl_pkg::OP_RIGHT;
                esc_next = 1'b0;
            end
            else if (key != gbl_pkg::KEY_BRACKET)
            begin
                esc_next = 1'b0;
            end
        end
        else if (key == gbl_pkg::KEY_DEL)
        begin
            kind = gbl_pkg::OP_DEL;
        end
        else if (key == gbl_pkg::KEY_ESC)
        begin
            esc_next = 1'b1;
        end
        else if (key inside {gbl_pkg::KEY_CR, gbl_pkg::KEY_QUIT})
        begin
            kind = gbl_pkg::OP_NOP;
        end
        else
        begin
            kind = gbl_pkg::OP_INS;
        end
    end

    always_comb
    begin
        q_data.kind     = kind;
        q_data.key      = key;
        q_data.position = position;
        q_data.esc      = esc_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esc_reg <= 1'b0;
        end
        else if (q_push)
        begin
            esc_reg <= esc_next;
        end
    end

endmodule

// ===== hdl/gbl_queue.sv =====
// Two-entry command queue between the front end and the edit engine.
`timescale 1ns / 1ps
module gbl_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  gbl_pkg::cmd_t din,
    output logic          full,
    input  logic          pop,
    output gbl_pkg::cmd_t dout,
    output logic          empty
);

    gbl_pkg::cmd_t entry_reg [2];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    count_reg;
    logic [1:0]    count_next;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign dout  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

// ===== hdl/gbl_back.sv =====
// Edit engine: owns the gap buffer, moves the gap, carries out commands.
`timescale 1ns / 1ps
module gbl_back #(
    parameter int CAPACITY = 256
) (
    input  logic          clk,
    input  logic          rst_n,
    input  gbl_pkg::cmd_t q_dout,
    input  logic          q_empty,
    output logic          q_pop,
    output logic          out_valid,
    input  logic          out_stall,
    output logic [8:0]    cursor,
    output logic [8:0]    text_length,
    output logic [7:0]    read_char,
    output logic          refused,
    output logic          escape_active
);

    localparam int PW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);
    localparam int XW = PW + 9;
    localparam logic [PW-1:0] CAP_P = PW'(CAPACITY);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_EXEC   = 5'b00010,
        S_MOVE   = 5'b00100,
        S_RDWAIT = 5'b01000,
        S_POST   = 5'b10000
    } state_t;

    state_t        state_reg, state_next;
    gbl_pkg::cmd_t cmd_reg, cmd_next;
    logic [PW-1:0] gs_reg, gs_next;     // first gap cell
    logic [PW-1:0] gt_reg, gt_next;     // first cell past the gap
    logic [PW-1:0] cur_reg, cur_next;
    logic          pend_reg, pend_next;
    logic [AW-1:0] pend_addr_reg, pend_addr_next;
    logic          hit_reg, hit_next;
    logic [7:0]    char_reg, char_next;
    logic          refused_reg, refused_next;
    logic          out_valid_reg, out_valid_next;
    logic [8:0]    cursor_reg, text_length_reg;
    logic [7:0]    read_char_reg;
    logic          refused_out_reg, escape_reg;
    logic          load_out;

    logic [7:0]    mem [CAPACITY];
    logic [7:0]    rdata_reg;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic [AW-1:0] mem_raddr;

    logic [PW-1:0] len;
    logic [XW-1:0] len_x, gs_x, gt_x, cur_x, pos_x, phys_x;
    logic          hit;

    assign len    = CAP_P - gt_reg + gs_reg;
    assign len_x  = {{9{1'b0}}, len};
    assign gs_x   = {{9{1'b0}}, gs_reg};
    assign gt_x   = {{9{1'b0}}, gt_reg};
    assign cur_x  = {{9{1'b0}}, cur_reg};
    assign pos_x  = {{(XW-8){1'b0}}, cmd_reg.position};
    assign hit    = (pos_x < len_x);
    // skip over the gap for positions at or past its start
    assign phys_x = (pos_x < gs_x) ? pos_x : (pos_x + gt_x - gs_x);

    assign load_out = (state_reg == S_POST) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        gs_next        = gs_reg;
        gt_next        = gt_reg;
        cur_next       = cur_reg;
        pend_next      = 1'b0;
        pend_addr_next = pend_addr_reg;
        hit_next       = hit_reg;
        char_next      = char_reg;
        refused_next   = refused_reg;
        q_pop          = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = pend_addr_reg;
        mem_wdata      = rdata_reg;
        mem_raddr      = phys_x[AW-1:0];

        // drain the copy issued last cycle
        if (pend_reg)
        begin
            mem_we = 1'b1;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    cmd_next   = q_dout;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                char_next    = 8'd0;
                refused_next = 1'b0;
                state_next   = S_POST;
                case (cmd_reg.kind)
                    gbl_pkg::OP_READ:
                    begin
                        hit_next   = hit;
                        state_next = S_RDWAIT;
                    end
                    gbl_pkg::OP_LEFT:
                    begin
                        if (cur_reg != '0)
                        begin
                            cur_next = cur_reg - PW'(1);
                        end
                    end
                    gbl_pkg::OP_RIGHT:
                    begin
                        if (cur_reg != len)
                        begin
                            cur_next = cur_reg + PW'(1);
                        end
                    end
                    gbl_pkg::OP_DEL:
                    begin
                        state_next = S_MOVE;
                    end
                    gbl_pkg::OP_INS:
                    begin
                        if (gs_reg == gt_reg)
                        begin
                            refused_next = 1'b1;
                        end
                        else
                        begin
                            state_next = S_MOVE;
                        end
                    end
                    default:
                    begin
                        state_next = S_POST;
                    end
                endcase
            end
            S_MOVE:
            begin
                if (gs_reg != cur_reg && gs_reg != gt_reg)
                begin
                    pend_next = 1'b1;
                    if (cur_reg < gs_reg)
                    begin
                        // shift one character from below the gap to its top
                        mem_raddr      = AW'(gs_reg - PW'(1));
                        pend_addr_next = AW'(gt_reg - PW'(1));
                        gs_next        = gs_reg - PW'(1);
                        gt_next        = gt_reg - PW'(1);
                    end
                    else
                    begin
                        mem_raddr      = AW'(gt_reg);
                        pend_addr_next = AW'(gs_reg);
                        gs_next        = gs_reg + PW'(1);
                        gt_next        = gt_reg + PW'(1);
                    end
                end
                else if (gs_reg != cur_reg)
                begin
                    // empty gap: nothing to copy, relocate it at once
                    gs_next = cur_reg;
                    gt_next = cur_reg;
                end
                else if (!pend_reg)
                begin
                    state_next = S_POST;
                    if (cmd_reg.kind == gbl_pkg::OP_INS)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = AW'(gs_reg);
                        mem_wdata = cmd_reg.key;
                        gs_next   = gs_reg + PW'(1);
                        cur_next  = cur_reg + PW'(1);
                    end
                    else if (cur_reg != '0)
                    begin
                        gs_next  = gs_reg - PW'(1);
                        cur_next = cur_reg - PW'(1);
                    end
                end
            end
            S_RDWAIT:
            begin
                char_next  = hit_reg ? rdata_reg : 8'd0;
                state_next = S_POST;
            end
            S_POST:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            gs_reg        <= '0;
            gt_reg        <= CAP_P;
            cur_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            gs_reg        <= gs_next;
            gt_reg        <= gt_next;
            cur_reg       <= cur_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        pend_addr_reg <= pend_addr_next;
        hit_reg       <= hit_next;
        char_reg      <= char_next;
        refused_reg   <= refused_next;
        if (load_out)
        begin
            cursor_reg      <= cur_x[8:0];
            text_length_reg <= len_x[8:0];
            read_char_reg   <= char_reg;
            refused_out_reg <= refused_reg;
            escape_reg      <= cmd_reg.esc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

    assign out_valid     = out_valid_reg;
    assign cursor        = cursor_reg;
    assign text_length   = text_length_reg;
    assign read_char     = read_char_reg;
    assign refused       = refused_out_reg;
    assign escape_active = escape_reg;

endmodule

// ===== tb/gap_buffer_line_editor_top_test.sv =====
// Self-checking testbench for the gap buffer line editor: directed table then random keystrokes.
`timescale 1ns / 1ps
module gap_buffer_line_editor_top_test;

    localparam int CAPACITY     = 256;
    localparam int RANDOM_WORDS = 1750;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 600;
    localparam int LIMIT_CYCLES = 3000000;

    typedef struct packed {
        logic [8:0] cur;
        logic [8:0] len;
        logic [7:0] chr;
        logic       full;
        logic       esc;
    } line_status_t;

    typedef struct packed {
        logic         op;
        logic [7:0]   k;
        logic [7:0]   p;
        logic         typed;
        line_status_t want;
    } probe_t;

    // Rows with typed set carry their expected status; the rest go through the predictor.
    localparam probe_t DIRECTED_WORDS [26] = '{
        '{gbl_pkg::OPC_READ, 8'hFF, 8'h00, 1'b1, '{9'd0, 9'd0, 8'h00, 1'b0, 1'b0}},
        '{gbl_pkg::OPC_KEY, gbl_pkg::KEY_DEL, 8'hFF, 1'b1, '{9'd0, 9'd0, 8'h00, 1'b0, 1'b0}},
        '{gbl_pkg::OPC_KEY, gbl_pkg::KEY_CR, 8'h00, 1'b1, '{9'd0, 9'd0, 8'h00, 1'b0, 1'b0}},
        '{gbl_pkg::OPC_KEY, gbl_pkg::KEY_QUIT, 8'hAA, 1'b1, '{9'd0, 9'd0, 8'h00, 1'b0, 1'b0}},
        '{gbl_pkg::OPC_KEY, gbl_pkg::KEY_ESC, 8'h55, 1'b1, '{9'd0, 9'd0, 8'h00, 1'b0, 1'b1}},
        '{gbl_pkg::OPC_KEY, gbl_pkg::KEY_LEFT, 8'h00, 1'b1, '{9'd0, 9'd0, 8'h00, 1'b0, 1'b0}},
        '{gbl_pkg::OPC_KEY, gbl_pkg::KEY_ESC, 8'h00, 1'b1, '{9'd0, 9'd0, 8'h00, 1'b0, 1'b1}},
        '{gbl_pkg::OPC_KEY, gbl_pkg::KEY_BRACKET, 8'h00, 1'b1, '{9'd0, 9'd0, 8'h00, 1'b0, 1'b1}},
        '{gbl_pkg::OPC_KEY, gbl_pkg::KEY_RIGHT, 8'h00, 1'b1, '{9'd0, 9'd0, 8'h00, 1'b0, 1'b0}},
        '{gbl_pkg::OPC_KEY, 8'h61, 8'hFF, 1'b1, '{9'd1, 9'd1, 8'h00, 1'b0, 1'b0}},
        '{gbl_pkg::OPC_KEY, 8'hFF, 8'h00, 1'b1, '{9'd2, 9'd2, 8'h00, 1'b0, 1'b0}},
        '{gbl_pkg::OPC_KEY, 8'h00, 8'h00, 1'b1, '{9'd3, 9'd3, 8'h00, 1'b0, 1'b0}},
        '{gbl_pkg::OPC_READ, 8'h00, 8'h00, 1'b1, '{9'd3, 9'd3, 8'h61, 1'b0, 1'b0}},
        '{gbl_pkg::OPC_READ, 8'hFF, 8'h01, 1'b1, '{9'd3, 9'd3, 8'hFF, 1'b0, 1'b0}},
        '{gbl_pkg::OPC_READ, 8'h00, 8'hFF, 1'b1, '{9'd3, 9'd3, 8'h00, 1'b0, 1'b0}},
        '{gbl_pkg::OPC_KEY, gbl_pkg::KEY_ESC, 8'h00, 1'b1, '{9'd3, 9'd3, 8'h00, 1'b0, 1'b1}},
        '{gbl_pkg::OPC_KEY, gbl_pkg::KEY_BRACKET, 8'h00, 1'b1, '{9'd3, 9'd3, 8'h00, 1'b0, 1'b1}},
        '{gbl_pkg::OPC_KEY, gbl_pkg::KEY_LEFT, 8'h00, 1'b1, '{9'd2, 9'd3, 8'h00, 1'b0, 1'b0}},
        '{gbl_pkg::OPC_KEY, gbl_pkg::KEY_ESC, 8'h00, 1'b1, '{9'd2, 9'd3, 8'h00, 1'b0, 1'b1}},
        '{gbl_pkg::OPC_KEY, gbl_pkg::KEY_LEFT, 8'h00, 1'b1, '{9'd1, 9'd3, 8'h00, 1'b0, 1'b0}},
        '{gbl_pkg::OPC_KEY, gbl_pkg::KEY_DEL, 8'h00, 1'b1, '{9'd0, 9'd2, 8'h00, 1'b0, 1'b0}},
        '{gbl_pkg::OPC_READ, 8'h00, 8'h00, 1'b1, '{9'd0, 9'd2, 8'hFF, 1'b0, 1'b0}},
        '{gbl_pkg::OPC_KEY, 8'h80, 8'h7F, 1'b0, '0},
        '{gbl_pkg::OPC_KEY, gbl_pkg::KEY_ESC, 8'h00, 1'b0, '0},
        '{gbl_pkg::OPC_READ, 8'h3C, 8'h02, 1'b0, '0},
        '{gbl_pkg::OPC_KEY, 8'h78, 8'h00, 1'b0, '0}
    };

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic       opcode;
    logic [7:0] key;
    logic [7:0] position;
    logic       out_valid;
    logic       out_stall;
    logic [8:0] cursor;
    logic [8:0] text_length;
    logic [7:0] read_char;
    logic       refused;
    logic       escape_active;

    gap_buffer_line_editor_top #(
        .CAPACITY(CAPACITY)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (opcode),
        .key          (key),
        .position     (position),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .cursor       (cursor),
        .text_length  (text_length),
        .read_char    (read_char),
        .refused      (refused),
        .escape_active(escape_active)
    );

    // Predicted editor state
    logic [7:0] text_mem [CAPACITY];
    int         gap_lo;
    int         gap_hi;
    int         caret;
    bit         esc_on;
    int         full_hits;

    line_status_t status_q [$];
    logic [7:0]   key_plan [$];
    bit           filling;
    int           send_idle;
    int           recv_idle;
    bit           hold_request;
    int           faults = 0;
    int unsigned  cycle_count = 0;

    initial clk = 1'b0;
    always #1 clk = ~clk;

    function automatic int line_len();
        return CAPACITY - gap_hi + gap_lo - 1;
    endfunction

    function automatic logic [7:0] peek(int idx);
        if (idx >= 0 && idx < CAPACITY)
            return text_mem[idx];
        return 8'h00;
    endfunction

    function automatic void poke(int idx, logic [7:0] v);
        if (idx >= 0 && idx < CAPACITY)
            text_mem[idx] = v;
    endfunction

    // Shift the gap to the caret one character at a time.
    function automatic void slide_gap();
        while (caret < gap_lo)
        begin
            gap_lo--;
            if (gap_lo < gap_hi)
                poke(gap_hi, peek(gap_lo));
            gap_hi--;
        end
        while (caret > gap_lo)
        begin
            gap_hi++;
            if (gap_lo < gap_hi)
                poke(gap_lo, peek(gap_hi));
            gap_lo++;
        end
    endfunction

    function automatic line_status_t edit_line(logic op, logic [7:0] k, logic [7:0] p);
        line_status_t st;
        int           phys;
        st = '0;
        if (op == gbl_pkg::OPC_READ)
        begin
            if (int'(p) < line_len())
            begin
                phys = int'(p);
                if (phys >= gap_lo)
                    phys += gap_hi - gap_lo + 1;
                st.chr = peek(phys);
            end
        end
        else if (esc_on)
        begin
            if (k == gbl_pkg::KEY_LEFT)
            begin
                if (caret > 0)
                    caret--;
                esc_on = 1'b0;
            end
            else if (k == gbl_pkg::KEY_RIGHT)
            begin
                if (caret < line_len())
                    caret++;
                esc_on = 1'b0;
            end
            else if (k != gbl_pkg::KEY_BRACKET)
                esc_on = 1'b0;
        end
        else if (k == gbl_pkg::KEY_DEL)
        begin
            slide_gap();
            if (caret > 0)
            begin
                gap_lo--;
                caret--;
            end
        end
        else if (k == gbl_pkg::KEY_ESC)
            esc_on = 1'b1;
        else if (k == gbl_pkg::KEY_CR || k == gbl_pkg::KEY_QUIT)
        begin
            // newline and quit are not handled by this block
        end
        else if (gap_lo > gap_hi)
        begin
            st.full = 1'b1;
            full_hits++;
        end
        else
        begin
            slide_gap();
            poke(gap_lo, k);
            gap_lo++;
            caret++;
        end
        st.cur = 9'(caret);
        st.len = 9'(line_len());
        st.esc = esc_on;
        return st;
    endfunction

    function automatic logic [7:0] pick_glyph();
        logic [7:0] g;
        do
            g = 8'($urandom_range(255));
        while (g == gbl_pkg::KEY_DEL || g == gbl_pkg::KEY_ESC || g == gbl_pkg::KEY_CR
               || g == gbl_pkg::KEY_QUIT);
        return g;
    endfunction

    function automatic void push_arrows(logic [7:0] dir, int count);
        repeat (count)
        begin
            key_plan.push_back(gbl_pkg::KEY_ESC);
            if ($urandom_range(4) != 0)
                key_plan.push_back(gbl_pkg::KEY_BRACKET);
            key_plan.push_back(dir);
        end
    endfunction

    // Queue the next keystroke sequence: grow the text until it is full, then shrink it.
    function automatic void plan_keystrokes();
        int r;
        int p_ins;
        int p_del;
        r     = $urandom_range(99);
        p_ins = filling ? 55 : 12;
        p_del = filling ? 10 : 50;
        if (!filling && caret == 0 && line_len() > 0)
            push_arrows(gbl_pkg::KEY_RIGHT, $urandom_range(1, 20));
        else if (r < p_ins)
            key_plan.push_back(pick_glyph());
        else if (r < p_ins + p_del)
            key_plan.push_back(gbl_pkg::KEY_DEL);
        else if (r < p_ins + p_del + 10)
            push_arrows(gbl_pkg::KEY_LEFT, 1);
        else if (r < p_ins + p_del + 18)
            push_arrows(gbl_pkg::KEY_RIGHT, 1);
        else if (r < p_ins + p_del + 21)
            push_arrows(gbl_pkg::KEY_LEFT, $urandom_range(2, 20));
        else if (r < p_ins + p_del + 23)
            push_arrows(gbl_pkg::KEY_RIGHT, $urandom_range(2, 20));
        else
        begin
            case ($urandom_range(3))
                0: key_plan.push_back(8'($urandom_range(255)));
                1:
                begin
                    key_plan.push_back(gbl_pkg::KEY_ESC);
                    key_plan.push_back(8'($urandom_range(255)));
                end
                2:
                begin
                    key_plan.push_back(gbl_pkg::KEY_ESC);
                    key_plan.push_back(gbl_pkg::KEY_BRACKET);
                    key_plan.push_back(8'($urandom_range(255)));
                end
                default:
                    key_plan.push_back($urandom_range(1) ? gbl_pkg::KEY_CR
                                                         : gbl_pkg::KEY_QUIT);
            endcase
        end
    endfunction

    // Offer one word from the falling edge and hold it until it is taken.
    task automatic offer_word(logic op, logic [7:0] k, logic [7:0] p);
        @(negedge clk);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        opcode   <= op;
        key      <= k;
        position <= p;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    function automatic void compare_field(string name, logic [8:0] want, logic [8:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            faults++;
        end
    endfunction

    initial
    begin : receiver
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(99) < recv_idle);
        end
    end

    always @(posedge clk)
    begin : watch_results
        line_status_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (status_q.size() == 0)
            begin
                $error("result word with nothing expected");
                faults++;
            end
            else
            begin
                want = status_q.pop_front();
                compare_field("cursor", want.cur, cursor);
                compare_field("text_length", want.len, text_length);
                compare_field("read_char", 9'(want.chr), 9'(read_char));
                compare_field("refused", 9'(want.full), 9'(refused));
                compare_field("escape_active", 9'(want.esc), 9'(escape_active));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == LIMIT_CYCLES)
        begin
            $display("gap_buffer_line_editor_top regression: fail");
            $finish;
        end
    end

    initial
    begin : stimulus
        line_status_t st;
        logic         op;
        logic [7:0]   k;
        logic [7:0]   p;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        opcode       = gbl_pkg::OPC_KEY;
        key          = 8'h00;
        position     = 8'h00;
        send_idle    = 36;
        recv_idle    = 67;
        hold_request = 1'b0;
        filling      = 1'b1;
        full_hits    = 0;
        gap_lo       = 0;
        gap_hi       = CAPACITY - 1;
        caret        = 0;
        esc_on       = 1'b0;
        foreach (text_mem[i])
            text_mem[i] = 8'h00;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (DIRECTED_WORDS[i])
        begin
            offer_word(DIRECTED_WORDS[i].op, DIRECTED_WORDS[i].k, DIRECTED_WORDS[i].p);
            st = edit_line(DIRECTED_WORDS[i].op, DIRECTED_WORDS[i].k, DIRECTED_WORDS[i].p);
            status_q.push_back(DIRECTED_WORDS[i].typed ? DIRECTED_WORDS[i].want : st);
        end

        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            if (n == RANDOM_WORDS / 3)
            begin
                send_idle = 67;
                recv_idle = 36;
            end
            if (n == 2 * RANDOM_WORDS / 3)
            begin
                // Hold the output off while words keep coming, so the input backs up.
                send_idle    = 0;
                recv_idle    = 0;
                hold_request = 1'b1;
            end
            if (filling && line_len() == CAPACITY && full_hits >= 6)
                filling = 1'b0;
            else if (!filling && line_len() <= 4)
            begin
                filling   = 1'b1;
                full_hits = 0;
            end

            if ($urandom_range(9) == 0)
            begin
                op = gbl_pkg::OPC_READ;
                k  = 8'($urandom_range(255));
                if (line_len() > 0 && $urandom_range(3) != 0)
                    p = 8'($urandom_range(line_len() - 1));
                else
                    p = 8'($urandom_range(255));
            end
            else
            begin
                if (key_plan.size() == 0)
                    plan_keystrokes();
                op = gbl_pkg::OPC_KEY;
                k  = key_plan.pop_front();
                p  = 8'($urandom_range(255));
            end
            offer_word(op, k, p);
            status_q.push_back(edit_line(op, k, p));
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (status_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (faults == 0)
            $display("gap_buffer_line_editor_top regression: pass");
        else
            $display("gap_buffer_line_editor_top regression: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/gbl_pkg.sv
hdl/gbl_front.sv
hdl/gbl_queue.sv
hdl/gbl_back.sv
hdl/gap_buffer_line_editor_top.sv
tb/gap_buffer_line_editor_top_test.sv
